// ===== sv/glpc_pkg.sv =====
package glpc_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int COUNT_W = 10;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_pd;
    logic p_from_quo;
    logic trial_init;
    logic d_next;
    logic cnt_dbl;
    logic cnt_clear;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic x_zero;
    logic rem_zero;
    logic p_zero;
    logic p_gt1;
    logic sq_le_p;
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

// ===== sv/glpc_div.sv =====
module glpc_div #(
  parameter int VALUE_BITS = glpc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [VALUE_BITS-1:0] remainder
);

  localparam int STEP_W = $clog2(VALUE_BITS);

  logic [STEP_W-1:0]     step;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] dvr;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;

  assign trial = {rem, quo[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dvr};
  assign ge    = !diff[VALUE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
      quo <= {quo[VALUE_BITS-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== sv/glpc_dp.sv =====
module glpc_dp #(
  parameter int VALUE_BITS = glpc_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  glpc_pkg::cmd_t                       cmd,
  output glpc_pkg::status_t                    status,
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0]    in_data,
  output logic [glpc_pkg::OUT_DATA_W-1:0]      out_data
);

  localparam int W  = VALUE_BITS;
  localparam int CW = glpc_pkg::COUNT_W;

  logic [W-1:0]    xr;
  logic [W-1:0]    yr;
  logic [W-1:0]    p;
  logic [W-1:0]    d;
  logic [2*W-1:0]  sq;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   res_cnt;
  logic            res_bad;
  logic [W-1:0]    div_n;
  logic [W-1:0]    div_d;
  logic [W-1:0]    quo;
  logic [W-1:0]    rem;
  logic            div_busy;
  logic            div_done;

  assign div_n = cmd.div_sel_pd ? p : yr;
  assign div_d = cmd.div_sel_pd ? d : xr;

  glpc_div #(.VALUE_BITS(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xr <= in_data[W-1:0];
      yr <= in_data[2*W-1:W];
    end
    if (cmd.p_from_quo) begin
      p <= quo;
    end
    if (cmd.trial_init) begin
      d  <= W'(2);
      sq <= (2*W)'(4);
    end else if (cmd.d_next) begin
      d  <= d + W'(1);
      sq <= sq + {{(W-1){1'b0}}, d, 1'b1};
    end
    if (cmd.cnt_clear) begin
      cnt <= '0;
    end else if (cmd.trial_init) begin
      cnt <= CW'(1);
    end else if (cmd.cnt_dbl) begin
      cnt <= cnt[CW-1] ? {CW{1'b1}} : {cnt[CW-2:0], 1'b0};
    end
    if (cmd.res_load) begin
      res_cnt <= cnt;
      res_bad <= (xr == '0);
    end
  end

  assign status.x_zero   = (xr == '0);
  assign status.rem_zero = (rem == '0);
  assign status.p_zero   = (p == '0);
  assign status.p_gt1    = (p > W'(1));
  assign status.sq_le_p  = (sq <= {{W{1'b0}}, p});
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;

  assign out_data = {{(glpc_pkg::OUT_DATA_W - CW - 1){1'b0}}, res_bad, res_cnt};

endmodule

// ===== sv/glpc_ctrl.sv =====
module glpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  glpc_pkg::status_t status,
  output glpc_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK_X  = 3'd1;
  localparam logic [2:0] S_WAIT_XY  = 3'd2;
  localparam logic [2:0] S_CHECK_P  = 3'd3;
  localparam logic [2:0] S_LOOP     = 3'd4;
  localparam logic [2:0] S_START_PD = 3'd5;
  localparam logic [2:0] S_WAIT_PD  = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       hit;
  logic       hit_next;
  logic       out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    hit_next   = hit;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK_X;
        end
      end
      S_CHECK_X: begin
        if (status.x_zero) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_WAIT_XY;
        end
      end
      S_WAIT_XY: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.p_from_quo = 1'b1;
            cmd.trial_init = 1'b1;
            hit_next       = 1'b0;
            state_next     = S_CHECK_P;
          end else begin
            cmd.cnt_clear = 1'b1;
            state_next    = S_FINISH;
          end
        end
      end
      S_CHECK_P: begin
        if (status.p_zero) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_FINISH;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (status.sq_le_p) begin
          cmd.div_start  = 1'b1;
          cmd.div_sel_pd = 1'b1;
          state_next     = S_WAIT_PD;
        end else begin
          cmd.cnt_dbl = status.p_gt1;
          state_next  = S_FINISH;
        end
      end
      S_START_PD: begin
        cmd.div_start  = 1'b1;
        cmd.div_sel_pd = 1'b1;
        state_next     = S_WAIT_PD;
      end
      S_WAIT_PD: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.p_from_quo = 1'b1;
            cmd.cnt_dbl    = !hit;
            hit_next       = 1'b1;
            state_next     = S_START_PD;
          end else begin
            cmd.d_next = 1'b1;
            hit_next   = 1'b0;
            state_next = S_LOOP;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      hit   <= hit_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  a_idle_no_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !status.div_busy)
    else $error("divider busy while idle");

  a_quo_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.p_from_quo |-> (status.div_done && status.rem_zero))
    else $error("quotient taken without an exact division");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> m_tvalid)
    else $error("result loaded but not presented");

endmodule

// ===== sv/gcd_lcm_pair_counter.sv =====
// Input accept to m_tvalid: a zero gcd goes straight to the result, an lcm that is not a
// multiple of the gcd ends after one division, a zero lcm after that division and a check
// of the quotient; else one division follows by each trial divisor d (one per d with
// d*d <= quotient, plus one per exact division), so a large prime quotient takes longest.
// One transaction at a time on a shared bit-serial divider; the next input is accepted in the
// cycle after the result is loaded. Synchronous active-high reset idles with no result held.
module gcd_lcm_pair_counter #(
  parameter int VALUE_BITS = glpc_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0: gcd_value, lcm_value, zero fill.
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // Fields from bit 0: pair_count (10 bits), bad_divisor (1 bit), zero fill.
  output logic [glpc_pkg::OUT_DATA_W-1:0]      m_tdata
);

  glpc_pkg::cmd_t    cmd;
  glpc_pkg::status_t status;

  glpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  glpc_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule
